// ----- hw/rtl/idhm_pkg.sv -----
package idhm_pkg;

  localparam int unsigned CapW = 12;
  localparam int unsigned IdW = 64;
  localparam int unsigned IxW = 10;
  localparam int unsigned CntW = 11;
  localparam int unsigned ModSteps = 4;
  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned MaxSlots = 2049;
  localparam logic [63:0] FibMul = 64'h9E3779B97F4A7C15;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_FIND_ID  = 2'd1,
    REQ_FIND_IX  = 2'd2,
    REQ_RESERVED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DENSE,
    B_PCHK
  } back_state_e;

  typedef struct packed {
    logic [1:0]      req;
    logic [IdW-1:0]  node_id;
    logic [IxW-1:0]  index_in;
    logic [CapW-1:0] home;
  } job_t;

endpackage

// ----- hw/rtl/idhm_front.sv -----
module idhm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [idhm_pkg::CapW-1:0]    cap_i,
  input  logic                         enable_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_i,
  input  logic [idhm_pkg::IdW-1:0]     node_id_i,
  input  logic [idhm_pkg::IxW-1:0]     index_in_i,
  output logic                         push_o,
  output idhm_pkg::job_t               job_o,
  input  logic                         full_i
);

  idhm_pkg::front_state_e state_q, state_d;
  logic [1:0]                  req_q;
  logic [idhm_pkg::IdW-1:0]    id_q;
  logic [idhm_pkg::IxW-1:0]    ix_q;
  logic [1:0]                  k_q, k_d;
  logic [63:0]                 acc_q, acc_d;
  logic [63:0]                 div_q, div_d;
  logic [idhm_pkg::CapW-1:0]   rem_q, rem_d;
  logic [3:0]                  step_q, step_d;
  logic                        accept;
  logic                        needs_hash;
  logic [63:0]                 prod;
  logic [15:0]                 chunk;
  logic [idhm_pkg::CapW:0]     r;
  logic [63:0]                 dv;

  assign accept = in_valid_i && in_ready_o;
  assign needs_hash = (req_i == idhm_pkg::REQ_INSERT || req_i == idhm_pkg::REQ_FIND_ID)
                      && (cap_i != '0);
  assign chunk = 16'(idhm_pkg::FibMul >> {k_q, 4'b0000});
  assign prod = id_q * {48'b0, chunk};

  always_comb begin
    r  = {1'b0, rem_q};
    dv = div_q;
    for (int s = 0; s < idhm_pkg::ModSteps; s++) begin
      r  = {r[idhm_pkg::CapW-1:0], dv[63]};
      dv = {dv[62:0], 1'b0};
      if (r >= {1'b0, cap_i}) begin
        r = r - {1'b0, cap_i};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idhm_pkg::F_IDLE: begin
        if (accept) begin
          state_d = needs_hash ? idhm_pkg::F_MUL : idhm_pkg::F_PUSH;
        end
      end
      idhm_pkg::F_MUL: begin
        if (k_q == 2'd3) begin
          state_d = idhm_pkg::F_MOD;
        end
      end
      idhm_pkg::F_MOD: begin
        if (step_q == 4'hF) begin
          state_d = idhm_pkg::F_PUSH;
        end
      end
      idhm_pkg::F_PUSH: begin
        if (!full_i) begin
          state_d = idhm_pkg::F_IDLE;
        end
      end
      default: state_d = idhm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    k_d    = k_q;
    acc_d  = acc_q;
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    in_ready_o = 1'b0;
    push_o = 1'b0;
    unique case (state_q)
      idhm_pkg::F_IDLE: begin
        in_ready_o = enable_i;
        k_d   = '0;
        acc_d = '0;
        rem_d = '0;
      end
      idhm_pkg::F_MUL: begin
        acc_d = acc_q + (prod << {k_q, 4'b0000});
        k_d   = k_q + 2'd1;
        div_d = acc_d;
        step_d = '0;
      end
      idhm_pkg::F_MOD: begin
        div_d  = dv;
        rem_d  = r[idhm_pkg::CapW-1:0];
        step_d = step_q + 4'd1;
      end
      idhm_pkg::F_PUSH: begin
        push_o = !full_i;
      end
      default: ;
    endcase
  end

  assign job_o = '{req: req_q, node_id: id_q, index_in: ix_q, home: rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idhm_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      id_q  <= node_id_i;
      ix_q  <= index_in_i;
    end
    k_q    <= k_d;
    acc_q  <= acc_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    step_q <= step_d;
  end

  a_rem_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idhm_pkg::F_MOD) |-> (rem_q < cap_i))
    else $error("hash remainder not below slot count");

endmodule

// ----- hw/rtl/idhm_queue.sv -----
module idhm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  idhm_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output idhm_pkg::job_t pop_data_o
);

  idhm_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> valid_o))
    else $error("queue overflow or underflow");

endmodule

// ----- hw/rtl/idhm_back.sv -----
module idhm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [idhm_pkg::CapW-1:0]    cap_i,
  output logic                         clear_done_o,
  input  logic                         q_valid_i,
  input  idhm_pkg::job_t               q_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [idhm_pkg::IxW-1:0]     index_out_o,
  output logic [idhm_pkg::IdW-1:0]     id_out_o,
  output logic [1:0]                   status_o,
  output logic [idhm_pkg::CntW-1:0]    node_count_o
);

  localparam int unsigned MAX_NODES = idhm_pkg::MaxNodes;
  localparam int unsigned MAX_SLOTS = idhm_pkg::MaxSlots;
  localparam int unsigned NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic                     used_mem [MAX_SLOTS];
  logic [idhm_pkg::IdW-1:0] key_mem  [MAX_SLOTS];
  logic [NIW-1:0]           idx_mem  [MAX_SLOTS];
  logic [idhm_pkg::IdW-1:0] dense_mem [MAX_NODES];

  idhm_pkg::back_state_e state_q, state_d;
  idhm_pkg::job_t           job_q, job_d;
  logic [NCW-1:0]           cnt_q, cnt_d;
  logic [idhm_pkg::CapW-1:0] p_q, p_d, j_q, j_d, p_nx;
  logic [SW-1:0]            clr_q;
  logic [SW-1:0]            rd_addr;
  logic                     rd_used_q;
  logic [idhm_pkg::IdW-1:0] rd_key_q;
  logic [NIW-1:0]           rd_idx_q;
  logic [idhm_pkg::IdW-1:0] rd_dense_q;
  logic                     slot_we, dense_we;
  logic                     out_valid_q;
  logic [idhm_pkg::IxW-1:0] index_q;
  logic [idhm_pkg::IdW-1:0] id_q;
  logic [1:0]               status_q;
  logic [idhm_pkg::CntW-1:0] count_q;
  logic                     res_valid;
  logic [idhm_pkg::IxW-1:0] res_index;
  logic [idhm_pkg::IdW-1:0] res_id;
  idhm_pkg::status_e        res_status;
  logic                     is_full, ix_ok, last, hit, done;

  assign clear_done_o = (state_q != idhm_pkg::B_CLEAR);
  assign pop_o = (state_q == idhm_pkg::B_IDLE) && q_valid_i && (!out_valid_q || out_ready_i);
  assign is_full = (32'(cnt_q) >= MAX_NODES);
  assign ix_ok   = (32'(q_data_i.index_in) < 32'(cnt_q));
  assign last    = ({1'b0, j_q} + 13'd1 == {1'b0, cap_i});
  assign p_nx    = ({1'b0, p_q} + 13'd1 >= {1'b0, cap_i}) ? '0 : p_q + 1'b1;
  assign hit     = rd_used_q && (rd_key_q == job_q.node_id);
  assign done    = !rd_used_q || last || (hit && job_q.req != idhm_pkg::REQ_INSERT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idhm_pkg::B_CLEAR: begin
        if (32'(clr_q) == MAX_SLOTS - 1) begin
          state_d = idhm_pkg::B_IDLE;
        end
      end
      idhm_pkg::B_IDLE: begin
        if (pop_o) begin
          case (q_data_i.req)
            idhm_pkg::REQ_INSERT: begin
              if (cap_i != '0 && !is_full) begin
                state_d = idhm_pkg::B_PCHK;
              end
            end
            idhm_pkg::REQ_FIND_ID: begin
              if (cap_i != '0) begin
                state_d = idhm_pkg::B_PCHK;
              end
            end
            idhm_pkg::REQ_FIND_IX: begin
              if (ix_ok) begin
                state_d = idhm_pkg::B_DENSE;
              end
            end
            default: ;
          endcase
        end
      end
      idhm_pkg::B_DENSE: state_d = idhm_pkg::B_IDLE;
      idhm_pkg::B_PCHK: begin
        if (done) begin
          state_d = idhm_pkg::B_IDLE;
        end
      end
      default: state_d = idhm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_d      = job_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    j_d        = j_q;
    rd_addr    = SW'(p_nx);
    slot_we    = 1'b0;
    dense_we   = 1'b0;
    res_valid  = 1'b0;
    res_index  = '0;
    res_id     = '0;
    res_status = idhm_pkg::ST_MISS;
    unique case (state_q)
      idhm_pkg::B_IDLE: begin
        rd_addr = SW'(q_data_i.home);
        p_d = q_data_i.home;
        j_d = '0;
        if (pop_o) begin
          job_d = q_data_i;
          case (q_data_i.req)
            idhm_pkg::REQ_INSERT: begin
              if (cap_i == '0 || is_full) begin
                res_valid  = 1'b1;
                res_status = idhm_pkg::ST_FULL;
              end
            end
            idhm_pkg::REQ_FIND_ID: begin
              res_valid = (cap_i == '0);
            end
            idhm_pkg::REQ_FIND_IX: begin
              res_valid = !ix_ok;
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      idhm_pkg::B_DENSE: begin
        res_valid  = 1'b1;
        res_status = idhm_pkg::ST_OK;
        res_index  = job_q.index_in;
        res_id     = rd_dense_q;
      end
      idhm_pkg::B_PCHK: begin
        p_d = p_nx;
        j_d = j_q + 1'b1;
        if (job_q.req == idhm_pkg::REQ_INSERT) begin
          if (!rd_used_q) begin
            slot_we    = 1'b1;
            dense_we   = 1'b1;
            cnt_d      = cnt_q + 1'b1;
            res_valid  = 1'b1;
            res_status = idhm_pkg::ST_OK;
            res_index  = idhm_pkg::IxW'(cnt_q);
            res_id     = job_q.node_id;
          end else if (last) begin
            res_valid  = 1'b1;
            res_status = idhm_pkg::ST_FULL;
          end
        end else begin
          if (hit) begin
            res_valid  = 1'b1;
            res_status = idhm_pkg::ST_OK;
            res_index  = idhm_pkg::IxW'(rd_idx_q);
            res_id     = job_q.node_id;
          end else if (done) begin
            res_valid  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idhm_pkg::B_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == idhm_pkg::B_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      cnt_q <= cnt_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    p_q   <= p_d;
    j_q   <= j_d;
    if (res_valid) begin
      index_q  <= res_index;
      id_q     <= res_id;
      status_q <= res_status;
      count_q  <= idhm_pkg::CntW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == idhm_pkg::B_CLEAR) begin
      used_mem[clr_q] <= 1'b0;
    end else if (slot_we) begin
      used_mem[SW'(p_q)] <= 1'b1;
      key_mem[SW'(p_q)]  <= job_q.node_id;
      idx_mem[SW'(p_q)]  <= NIW'(cnt_q);
    end
    rd_used_q <= used_mem[rd_addr];
    rd_key_q  <= key_mem[rd_addr];
    rd_idx_q  <= idx_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dense_we) begin
      dense_mem[NIW'(cnt_q)] <= job_q.node_id;
    end
    rd_dense_q <= dense_mem[NIW'(q_data_i.index_in)];
  end

  assign out_valid_o  = out_valid_q;
  assign index_out_o  = index_q;
  assign id_out_o     = id_q;
  assign status_o     = status_q;
  assign node_count_o = count_q;

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result produced while output register busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_NODES)
    else $error("node count above capacity");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idhm_pkg::B_CLEAR) |-> !pop_o)
    else $error("request taken during clearing pass");

endmodule

// ----- hw/rtl/id_to_dense_index_hash_map.sv -----
// Channel   | Direction | tdata (low bit up)                      | tuser
// s_axis    | in        | node_id[63:0], index_in[73:64]          | req_type[1:0]
// m_axis    | out       | index_out[9:0], id_out[73:10],          | status[1:0]
//           |           | node_count[84:74]                       |
// cfg       | in        | slot_count[11:0] on cfg_wdata_i         | -
// The front hashes each request with a 64x16 multiply in four 16-bit chunks
// and a four-bit-per-cycle modulo by the slot count.
// The back then probes one slot per cycle through the registered slot memory read port.
// After reset a clearing pass over all 2049 slots, one slot per cycle, runs before the first request is taken.
// A two-entry queue lets the front hash ahead while the back probes or the output stalls.
module id_to_dense_index_hash_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // node_id, index_in
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // index_out, id_out, node_count
  output logic [1:0]  m_axis_tuser    // status
);

  logic [idhm_pkg::CapW-1:0] slot_count_q;
  logic [idhm_pkg::CapW-1:0] cap;
  logic           clear_done, push, full, pop, q_valid;
  idhm_pkg::job_t push_job, pop_job;
  logic [idhm_pkg::IxW-1:0]  index_out;
  logic [idhm_pkg::IdW-1:0]  id_out;
  logic [idhm_pkg::CntW-1:0] node_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  assign cap = ({20'b0, slot_count_q} > idhm_pkg::MaxSlots) ?
               idhm_pkg::CapW'(idhm_pkg::MaxSlots) : slot_count_q;

  idhm_front u_front (
    .clk_i,
    .rst_ni,
    .cap_i      (cap),
    .enable_i   (clear_done),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (s_axis_tuser),
    .node_id_i  (s_axis_tdata[63:0]),
    .index_in_i (s_axis_tdata[73:64]),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  idhm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  idhm_back u_back (
    .clk_i,
    .rst_ni,
    .cap_i        (cap),
    .clear_done_o (clear_done),
    .q_valid_i    (q_valid),
    .q_data_i     (pop_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .index_out_o  (index_out),
    .id_out_o     (id_out),
    .status_o     (m_axis_tuser),
    .node_count_o (node_count)
  );

  assign m_axis_tdata = {3'b000, node_count, id_out, index_out};

endmodule
